/* design/msc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msc_pkg: shared types and constants of the material sample classifier
// Field widths, register codes, reset values and the decision encoding.
// ----------------------------------------------------------------------------
package msc_pkg;

    localparam int SAMPLE_W   = 10;
    localparam int COUNT_W    = 4;
    localparam int HOLD_W     = 16;
    localparam int MAT_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MEASURE_LEVEL   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PLASTIC_LEVEL   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_METAL_LEVEL     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAPER_COUNT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF_SAMPLES = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [SAMPLE_W-1:0] RST_MEASURE_LEVEL   = 10'd840;
    localparam logic [SAMPLE_W-1:0] RST_PLASTIC_LEVEL   = 10'd740;
    localparam logic [SAMPLE_W-1:0] RST_METAL_LEVEL     = 10'd680;
    localparam logic [COUNT_W-1:0]  RST_PAPER_COUNT     = 4'd10;
    localparam logic [HOLD_W-1:0]   RST_HOLDOFF_SAMPLES = 16'd15000;

    // Reset value of the previous sample.
    localparam logic [SAMPLE_W-1:0] RST_LAST_SAMPLE = 10'd890;

    typedef enum logic [MAT_W-1:0] {
        MAT_NONE    = 2'd0,
        MAT_PLASTIC = 2'd1,
        MAT_METAL   = 2'd2,
        MAT_PAPER   = 2'd3
    } t_material;

    typedef struct packed {
        logic [SAMPLE_W-1:0] measure_level;
        logic [SAMPLE_W-1:0] plastic_level;
        logic [SAMPLE_W-1:0] metal_level;
        logic [COUNT_W-1:0]  paper_count;
        logic [HOLD_W-1:0]   holdoff_samples;
    } t_cfg;

endpackage

/* design/msc_sample_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msc_sample_if: sample channel
// Valid/ready channel that carries one 10-bit converter reading per transfer.
// ----------------------------------------------------------------------------
interface msc_sample_if import msc_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);

endinterface

/* design/msc_material_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msc_material_if: decision channel
// Valid/ready channel that carries one 2-bit material decision per transfer.
// ----------------------------------------------------------------------------
interface msc_material_if import msc_pkg::*; ();

    logic             valid;
    logic             ready;
    logic [MAT_W-1:0] material;

    modport source (output valid, output material, input ready);
    modport sink   (input valid, input material, output ready);

endinterface

/* design/msc_cfg_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msc_cfg_regs: configuration register file
// Decodes the write port into the five threshold and count registers.
// ----------------------------------------------------------------------------
module msc_cfg_regs import msc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MEASURE_LEVEL:   n_cfg.measure_level   = i_cfg_data[SAMPLE_W-1:0];
                CFG_PLASTIC_LEVEL:   n_cfg.plastic_level   = i_cfg_data[SAMPLE_W-1:0];
                CFG_METAL_LEVEL:     n_cfg.metal_level     = i_cfg_data[SAMPLE_W-1:0];
                CFG_PAPER_COUNT:     n_cfg.paper_count     = i_cfg_data[COUNT_W-1:0];
                CFG_HOLDOFF_SAMPLES: n_cfg.holdoff_samples = i_cfg_data[HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.measure_level   <= RST_MEASURE_LEVEL;
            r_cfg.plastic_level   <= RST_PLASTIC_LEVEL;
            r_cfg.metal_level     <= RST_METAL_LEVEL;
            r_cfg.paper_count     <= RST_PAPER_COUNT;
            r_cfg.holdoff_samples <= RST_HOLDOFF_SAMPLES;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* design/msc_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msc_core: classification state and decision logic
// Holds the holdoff count, measuring flag, low count and previous sample,
// and forms the decision for the sample that is transferred this cycle.
// ----------------------------------------------------------------------------
module msc_core import msc_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cfg                i_cfg,
    input  logic                i_accept,
    input  logic [SAMPLE_W-1:0] i_sample,
    output t_material           o_material
);

    logic [HOLD_W-1:0]   r_holdoff;
    logic                r_measuring;
    logic [COUNT_W-1:0]  r_low_seen;
    logic [SAMPLE_W-1:0] r_last_sample;

    logic [HOLD_W-1:0]   n_holdoff;
    logic                n_measuring;
    logic [COUNT_W-1:0]  n_low_seen;

    logic                hold_busy;
    logic                above_measure;
    logic                low_sample;
    logic [COUNT_W-1:0]  low_inc;
    t_material           mat;

    assign hold_busy     = (r_holdoff != '0);
    assign above_measure = (i_sample > i_cfg.measure_level);
    assign low_inc       = (r_low_seen < i_cfg.paper_count) ? r_low_seen + 1'b1 : r_low_seen;

    always_comb begin
        n_holdoff   = r_holdoff;
        n_measuring = r_measuring;
        n_low_seen  = r_low_seen;
        mat         = MAT_NONE;

        // Holdoff or start/plastic step first; the low-sample step then sees
        // the updated measuring flag.
        if (hold_busy) begin
            n_holdoff = r_holdoff - 1'b1;
        end else if (above_measure) begin
            if (!r_measuring) begin
                n_measuring = 1'b1;
            end else if (r_last_sample < i_cfg.measure_level) begin
                mat         = MAT_PLASTIC;
                n_measuring = 1'b0;
            end
        end

        low_sample = n_measuring && (i_sample < i_cfg.measure_level)
                     && (i_sample < i_cfg.plastic_level);

        if (low_sample) begin
            n_low_seen = low_inc;
            if (i_sample < i_cfg.metal_level) begin
                mat         = MAT_METAL;
                n_measuring = 1'b0;
                n_holdoff   = i_cfg.holdoff_samples;
            end else if (low_inc >= i_cfg.paper_count) begin
                mat         = MAT_PAPER;
                n_measuring = 1'b0;
                n_low_seen  = '0;
                n_holdoff   = i_cfg.holdoff_samples;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_holdoff     <= '0;
            r_measuring   <= 1'b1;
            r_low_seen    <= '0;
            r_last_sample <= RST_LAST_SAMPLE;
        end else if (i_accept) begin
            r_holdoff     <= n_holdoff;
            r_measuring   <= n_measuring;
            r_low_seen    <= n_low_seen;
            r_last_sample <= i_sample;
        end
    end

    assign o_material = mat;

endmodule

/* design/msc_out_buf.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msc_out_buf: result register with skid stage
// Two-entry output buffer so a new sample is taken while a result waits.
// ----------------------------------------------------------------------------
module msc_out_buf import msc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_material i_material,
    output logic      o_can_push,
    output logic      o_valid,
    input  logic      i_ready,
    output t_material o_material
);

    logic      r_main_valid;
    logic      r_skid_valid;
    t_material r_main;
    t_material r_skid;

    logic      n_main_valid;
    logic      n_skid_valid;
    t_material n_main;
    t_material n_skid;

    logic      take;

    assign take = r_main_valid && i_ready;

    always_comb begin
        n_main_valid = r_main_valid;
        n_skid_valid = r_skid_valid;
        n_main       = r_main;
        n_skid       = r_skid;
        if (!r_main_valid || take) begin
            // The main slot frees up: the older skid entry moves forward first.
            if (r_skid_valid) begin
                n_main       = r_skid;
                n_main_valid = 1'b1;
                n_skid_valid = i_push;
                n_skid       = i_material;
            end else begin
                n_main       = i_material;
                n_main_valid = i_push;
            end
        end else if (i_push) begin
            n_skid       = i_material;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_main_valid <= n_main_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_main <= n_main;
        r_skid <= n_skid;
    end

    assign o_can_push = !r_skid_valid;
    assign o_valid    = r_main_valid;
    assign o_material = r_main;

endmodule

/* design/material_sample_classifier.sv */
`timescale 1ns / 1ps
// A decision is registered into the output buffer when its sample is taken.
// One sample per cycle is taken while the output buffer's skid slot is free.
// A two-entry output buffer keeps the input ready while one result waits.
// Reset (synchronous, active low) loads the default thresholds, sets measuring,
// clears the holdoff and low counts and empties the output buffer.
// ----------------------------------------------------------------------------
// material_sample_classifier: top level
// Classifies objects as plastic, metal or paper from converter samples.
// ----------------------------------------------------------------------------
module material_sample_classifier import msc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    msc_sample_if.sink            i_smp,
    msc_material_if.source        o_mat
);

    t_cfg      cfg;
    logic      accept;
    logic      can_push;
    t_material core_mat;
    t_material buf_mat;

    assign accept      = i_smp.valid && can_push;
    assign i_smp.ready = can_push;

    msc_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    msc_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_accept   (accept),
        .i_sample   (i_smp.sample),
        .o_material (core_mat)
    );

    msc_out_buf u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (accept),
        .i_material (core_mat),
        .o_can_push (can_push),
        .o_valid    (o_mat.valid),
        .i_ready    (o_mat.ready),
        .o_material (buf_mat)
    );

    assign o_mat.material = buf_mat;

    // Every transfer in leaves a result pending in the next cycle.
    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_smp.valid && i_smp.ready) |=> o_mat.valid)
        else $error("no result after a sample transfer");

    // The input only stalls when both buffer entries are full.
    a_stall_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_smp.ready |-> o_mat.valid)
        else $error("input stalled with an empty output");

    // Reset empties the output buffer.
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_mat.valid && i_smp.ready))
        else $error("output buffer not empty after reset");

endmodule

/* tb/msc_scoreboard_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msc_scoreboard_pkg: decision scoreboard of the material sample classifier
// Mirrors the thresholds and the classifier state, predicts one material
// decision per accepted sample and checks the decisions in arrival order.
// ----------------------------------------------------------------------------
package msc_scoreboard_pkg;

    import msc_pkg::*;

    class material_scoreboard;

        // Mirrored threshold registers.
        logic [SAMPLE_W-1:0] measure_lvl;
        logic [SAMPLE_W-1:0] plastic_lvl;
        logic [SAMPLE_W-1:0] metal_lvl;
        logic [COUNT_W-1:0]  paper_cnt;
        logic [HOLD_W-1:0]   holdoff_len;

        // Mirrored classifier state.
        logic [HOLD_W-1:0]   hold_left;
        bit                  measuring;
        logic [COUNT_W-1:0]  low_cnt;
        logic [SAMPLE_W-1:0] prev_sample;

        t_material expected_materials[$];
        int        mismatches;
        int        samples_noted;
        int        decisions_checked;
        int        decided[4];

        function new();
            measure_lvl = RST_MEASURE_LEVEL;
            plastic_lvl = RST_PLASTIC_LEVEL;
            metal_lvl   = RST_METAL_LEVEL;
            paper_cnt   = RST_PAPER_COUNT;
            holdoff_len = RST_HOLDOFF_SAMPLES;
            hold_left   = '0;
            measuring   = 1'b1;
            low_cnt     = '0;
            prev_sample = RST_LAST_SAMPLE;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_MEASURE_LEVEL:   measure_lvl = data[SAMPLE_W-1:0];
                CFG_PLASTIC_LEVEL:   plastic_lvl = data[SAMPLE_W-1:0];
                CFG_METAL_LEVEL:     metal_lvl   = data[SAMPLE_W-1:0];
                CFG_PAPER_COUNT:     paper_cnt   = data[COUNT_W-1:0];
                CFG_HOLDOFF_SAMPLES: holdoff_len = data[HOLD_W-1:0];
                default: ;
            endcase
        endfunction

        // One classifier step: the holdoff or start/plastic decision comes first,
        // then the low-sample step sees the updated measuring flag.
        function t_material classify_sample(logic [SAMPLE_W-1:0] s);
            t_material mat;
            mat = MAT_NONE;
            if (hold_left != 0) begin
                hold_left = hold_left - 1'b1;
            end else if (s > measure_lvl) begin
                if (!measuring) begin
                    measuring = 1'b1;
                end else if (prev_sample < measure_lvl) begin
                    mat = MAT_PLASTIC;
                    measuring = 1'b0;
                end
            end
            if (measuring && s < measure_lvl && s < plastic_lvl) begin
                if (low_cnt < paper_cnt)
                    low_cnt = low_cnt + 1'b1;
                if (s < metal_lvl) begin
                    mat = MAT_METAL;
                    measuring = 1'b0;
                    hold_left = holdoff_len;
                end else if (low_cnt >= paper_cnt) begin
                    mat = MAT_PAPER;
                    measuring = 1'b0;
                    low_cnt = '0;
                    hold_left = holdoff_len;
                end
            end
            prev_sample = s;
            return mat;
        endfunction

        function void note_sample(logic [SAMPLE_W-1:0] s);
            samples_noted++;
            expected_materials.push_back(classify_sample(s));
        endfunction

        function void report(string what, int want, logic [MAT_W-1:0] got);
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] %s: expected %0d, actual %0d", $time, what, want, got);
        endfunction

        function void check_material(logic [MAT_W-1:0] got);
            t_material want;
            decisions_checked++;
            if (expected_materials.size() == 0) begin
                report("decision with no sample pending", -1, got);
            end else begin
                want = expected_materials.pop_front();
                if (got !== want)
                    report("material mismatch", want, got);
                else
                    decided[want]++;
            end
        endfunction

        function int pending();
            return expected_materials.size();
        endfunction

    endclass

endpackage

/* tb/tb_material_sample_classifier.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_material_sample_classifier: testbench of the material sample classifier
// Runs a directed object sequence at the default thresholds, then random
// object passages under a dozen threshold settings with random gaps and
// output stalls, and checks every decision against a scoreboard model.
// ----------------------------------------------------------------------------
module tb_material_sample_classifier;

    import msc_pkg::*;
    import msc_scoreboard_pkg::*;

    localparam int SAMPLE_MAX   = (1 << SAMPLE_W) - 1;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 127;

    typedef enum int {
        SHAPE_PLASTIC,
        SHAPE_PAPER,
        SHAPE_METAL,
        SHAPE_MIXED
    } t_shape;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx    = CFG_MEASURE_LEVEL;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;
    logic                  smp_valid  = 1'b0;
    logic [SAMPLE_W-1:0]   smp_sample = '0;
    logic                  mat_ready  = 1'b0;

    bit   idle_on = 1'b1;
    int   stall_left = 0;
    int   stall_roll;
    int   cycles = 0;
    int   samples_sent = 0;
    int   phase_start;
    t_cfg cur_cfg;

    material_scoreboard sb = new();

    msc_sample_if   smp_if();
    msc_material_if mat_if();

    assign smp_if.valid  = smp_valid;
    assign smp_if.sample = smp_sample;
    assign mat_if.ready  = mat_ready;

    material_sample_classifier dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_smp      (smp_if.sink),
        .o_mat      (mat_if.source)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d decisions pending", cycles, sb.pending());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // The sample is noted before the decision check in case both transfers share an edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (smp_if.valid && smp_if.ready)
                sb.note_sample(smp_if.sample);
            if (mat_if.valid && mat_if.ready)
                sb.check_material(mat_if.material);
        end
    end

    // Decision sink: mostly ready, with short and occasionally long stalls.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            mat_ready <= 1'b0;
        end else begin
            stall_roll = $urandom_range(99, 0);
            if (!idle_on || stall_roll < 70) begin
                mat_ready <= 1'b1;
            end else begin
                stall_left = (stall_roll < 94) ? $urandom_range(2, 0) : $urandom_range(40, 10);
                mat_ready <= 1'b0;
            end
        end
    end

    function automatic int gap_length();
        int r;
        r = $urandom_range(99, 0);
        if (!idle_on || r < 70)
            return 0;
        if (r < 93)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    function automatic logic [SAMPLE_W-1:0] sample_between(int lo, int hi);
        if (lo > hi)
            return SAMPLE_W'($urandom_range(SAMPLE_MAX, 0));
        return SAMPLE_W'($urandom_range(hi, lo));
    endfunction

    // Sample bands relative to the thresholds that are currently programmed.
    function automatic logic [SAMPLE_W-1:0] above_sample();
        return sample_between(int'(cur_cfg.measure_level) + 1, SAMPLE_MAX);
    endfunction

    function automatic logic [SAMPLE_W-1:0] mid_sample();
        return sample_between(int'(cur_cfg.plastic_level), int'(cur_cfg.measure_level) - 1);
    endfunction

    function automatic logic [SAMPLE_W-1:0] low_sample();
        return sample_between(int'(cur_cfg.metal_level), int'(cur_cfg.plastic_level) - 1);
    endfunction

    function automatic logic [SAMPLE_W-1:0] metal_sample();
        return sample_between(0, int'(cur_cfg.metal_level) - 1);
    endfunction

    function automatic logic [SAMPLE_W-1:0] any_sample();
        case ($urandom_range(7, 0))
            0: return cur_cfg.measure_level;
            1: return cur_cfg.plastic_level;
            2: return cur_cfg.metal_level;
            3: return above_sample();
            4: return mid_sample();
            5: return low_sample();
            6: return metal_sample();
            default: return SAMPLE_W'($urandom_range(SAMPLE_MAX, 0));
        endcase
    endfunction

    function automatic t_cfg sorted_levels(t_cfg c);
        logic [SAMPLE_W-1:0] a, b, m, t;
        a = SAMPLE_W'($urandom_range(SAMPLE_MAX, 0));
        b = SAMPLE_W'($urandom_range(SAMPLE_MAX, 0));
        m = SAMPLE_W'($urandom_range(SAMPLE_MAX, 0));
        if (a < b) begin t = a; a = b; b = t; end
        if (b < m) begin t = b; b = m; m = t; end
        if (a < b) begin t = a; a = b; b = t; end
        c.measure_level = a;
        c.plastic_level = b;
        c.metal_level   = m;
        return c;
    endfunction

    function automatic t_cfg make_cfg(int ph);
        t_cfg c;
        c.measure_level   = RST_MEASURE_LEVEL;
        c.plastic_level   = RST_PLASTIC_LEVEL;
        c.metal_level     = RST_METAL_LEVEL;
        c.paper_count     = RST_PAPER_COUNT;
        c.holdoff_samples = HOLD_W'(3);
        case (ph)
            0: ;
            1: begin
                c.paper_count     = COUNT_W'(15);
                c.holdoff_samples = '0;
            end
            2: begin
                c.paper_count     = COUNT_W'(1);
                c.holdoff_samples = HOLD_W'(5);
            end
            3: begin
                c = sorted_levels(c);
                c.paper_count     = '0;
                c.holdoff_samples = HOLD_W'(2);
            end
            4: begin
                c.measure_level   = '1;
                c.plastic_level   = '1;
                c.metal_level     = '1;
                c.paper_count     = COUNT_W'(3);
                c.holdoff_samples = HOLD_W'(1);
            end
            5: begin
                c.measure_level   = '0;
                c.plastic_level   = '0;
                c.metal_level     = '0;
                c.paper_count     = COUNT_W'(4);
                c.holdoff_samples = HOLD_W'(7);
            end
            11: begin
                c.measure_level   = SAMPLE_W'($urandom_range(SAMPLE_MAX, 0));
                c.plastic_level   = SAMPLE_W'($urandom_range(SAMPLE_MAX, 0));
                c.metal_level     = SAMPLE_W'($urandom_range(SAMPLE_MAX, 0));
                c.paper_count     = COUNT_W'($urandom_range(15, 0));
                c.holdoff_samples = HOLD_W'($urandom_range(12, 0));
            end
            PHASES: begin
                c.paper_count     = COUNT_W'(2);
                c.holdoff_samples = '1;
            end
            default: begin
                c = sorted_levels(c);
                c.paper_count     = COUNT_W'($urandom_range(15, 0));
                c.holdoff_samples = HOLD_W'($urandom_range(20, 0));
            end
        endcase
        return c;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        sb.set_register(idx, data);
    endtask

    // Upper data bits beyond a register's width are random and must be ignored.
    task automatic apply_cfg(input t_cfg c, input bit stray_writes);
        logic [CFG_DATA_W-1:0] d;
        d = CFG_DATA_W'($urandom());
        d[SAMPLE_W-1:0] = c.measure_level;
        write_reg(CFG_MEASURE_LEVEL, d);
        d = CFG_DATA_W'($urandom());
        d[SAMPLE_W-1:0] = c.plastic_level;
        write_reg(CFG_PLASTIC_LEVEL, d);
        d = CFG_DATA_W'($urandom());
        d[SAMPLE_W-1:0] = c.metal_level;
        write_reg(CFG_METAL_LEVEL, d);
        d = CFG_DATA_W'($urandom());
        d[COUNT_W-1:0] = c.paper_count;
        write_reg(CFG_PAPER_COUNT, d);
        write_reg(CFG_HOLDOFF_SAMPLES, c.holdoff_samples);
        if (stray_writes) begin
            for (int k = CFG_HOLDOFF_SAMPLES + 1; k < (1 << CFG_IDX_W); k++)
                write_reg(CFG_IDX_W'(k), CFG_DATA_W'($urandom()));
        end
        @(negedge i_clk);
        cfg_we <= 1'b0;
        cur_cfg = c;
    endtask

    task automatic send_sample(input logic [SAMPLE_W-1:0] s);
        repeat (gap_length()) begin
            @(negedge i_clk);
            smp_valid <= 1'b0;
        end
        @(negedge i_clk);
        smp_valid  <= 1'b1;
        smp_sample <= s;
        do @(posedge i_clk); while (!smp_if.ready);
        samples_sent++;
    endtask

    // Let the last decisions drain so the thresholds can be rewritten safely.
    task automatic drain();
        @(negedge i_clk);
        smp_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // One object passing the sensor: empty-sensor readings around a body of
    // samples shaped like a plastic, paper or metal object, or a random mix.
    task automatic run_object();
        t_shape shape;
        shape = t_shape'($urandom_range(SHAPE_MIXED, SHAPE_PLASTIC));
        repeat ($urandom_range(4, 1)) send_sample(above_sample());
        case (shape)
            SHAPE_PLASTIC: repeat ($urandom_range(5, 1)) send_sample(mid_sample());
            SHAPE_PAPER:   repeat ($urandom_range(18, 1)) send_sample(low_sample());
            SHAPE_METAL: begin
                repeat ($urandom_range(4, 0)) send_sample(low_sample());
                send_sample(metal_sample());
            end
            default:       repeat ($urandom_range(10, 1)) send_sample(any_sample());
        endcase
        repeat ($urandom_range(3, 1)) send_sample(above_sample());
    endtask

    logic [SAMPLE_W-1:0] directed_samples[25] = '{
        1023, 840, 900, 800, 900, 900, 740,
        700, 700, 700, 700, 700, 700, 700, 700, 700, 700,
        1023, 0, 1023, 1023, 680, 0, 500, 1023
    };

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Default thresholds with a short holdoff: empty sensor, level ties,
        // plastic, a full paper count, holdoff countdown, then metal.
        apply_cfg(make_cfg(0), 1'b0);
        foreach (directed_samples[k])
            send_sample(directed_samples[k]);
        drain();

        for (int ph = 1; ph <= PHASES; ph++) begin
            apply_cfg(make_cfg(ph), ph == 6);
            idle_on = (ph % 4 != 2);
            phase_start = samples_sent;
            while (samples_sent - phase_start < PHASE_ITEMS) begin
                if ($urandom_range(9, 0) == 0)
                    repeat ($urandom_range(5, 1))
                        send_sample(SAMPLE_W'($urandom_range(SAMPLE_MAX, 0)));
                else
                    run_object();
            end
            drain();
        end

        $display("Sent %0d samples under %0d threshold settings in %0d cycles.",
                 samples_sent, PHASES + 1, cycles);
        $display("Decisions seen: none %0d, plastic %0d, metal %0d, paper %0d; errors %0d.",
                 sb.decided[MAT_NONE], sb.decided[MAT_PLASTIC], sb.decided[MAT_METAL],
                 sb.decided[MAT_PAPER], sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* sim.f */
design/msc_pkg.sv
design/msc_sample_if.sv
design/msc_material_if.sv
design/msc_cfg_regs.sv
design/msc_core.sv
design/msc_out_buf.sv
design/material_sample_classifier.sv
tb/msc_scoreboard_pkg.sv
tb/tb_material_sample_classifier.sv
